[src/vtp_pkg.sv]
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants for the vector triple product unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

    // width of every result field
    localparam int OUT_WIDTH = 49;

    // operation select
    typedef enum logic [1:0] {
        ACT_DOT      = 2'd0,
        ACT_CROSS    = 2'd1,
        ACT_TRIPLE_S = 2'd2,
        ACT_TRIPLE_V = 2'd3
    } t_action;

    // per-lane stage control from the top level
    typedef struct packed {
        logic    en_a;
        logic    en_b;
        logic    en_c;
        t_action act_a;
        t_action act_c;
    } t_lane_ctl;

endpackage

`default_nettype wire

[src/vtp_lane.sv]
// ----------------------------------------------------------------------------
// vtp_lane
// One component lane: first products, first cross component, second products.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_lane #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire                                     i_clk,
    input  wire vtp_pkg::t_lane_ctl                 i_ctl,
    // operands for stage a (k, k+1, k+2 rotated per lane)
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_a_k,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_a_k1,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_a_k2,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_b_k,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_b_k1,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_b_k2,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_c_k1,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_c_k2,
    // delayed a for stage c
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_ad_k,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_ad_k1,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_ad_k2,
    // neighbor lanes' first cross components
    input  wire logic signed [2*COMPONENT_WIDTH:0]  i_t_k1,
    input  wire logic signed [2*COMPONENT_WIDTH:0]  i_t_k2,
    output logic signed [2*COMPONENT_WIDTH:0]       o_t,
    output logic signed [2*COMPONENT_WIDTH:0]       o_t_c,
    output logic signed [3*COMPONENT_WIDTH:0]       o_q0,
    output logic signed [3*COMPONENT_WIDTH:0]       o_q1
);
    import vtp_pkg::*;

    localparam int PW = 2 * COMPONENT_WIDTH;
    localparam int TW = 2 * COMPONENT_WIDTH + 1;
    localparam int QW = 3 * COMPONENT_WIDTH + 1;

    logic                             w_dot;
    logic                             w_abp;
    logic                             w_tri_s;
    logic signed [COMPONENT_WIDTH-1:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [COMPONENT_WIDTH-1:0] w_u0;
    logic signed [TW-1:0]             w_v0;
    logic signed [PW-1:0]             r_m0, r_m1;
    logic signed [TW-1:0]             r_t, r_t_c;
    logic signed [QW-1:0]             r_q0, r_q1;

    // stage a operand select: dot uses (a_k, b_k), cross of a,b or of b,c
    assign w_dot   = (i_ctl.act_a == ACT_DOT);
    assign w_abp   = (i_ctl.act_a inside {ACT_DOT, ACT_CROSS});
    assign w_x0    = w_dot ? i_a_k : (w_abp ? i_a_k1 : i_b_k1);
    assign w_y0    = w_dot ? i_b_k : (w_abp ? i_b_k2 : i_c_k2);
    assign w_x1    = w_abp ? i_a_k2 : i_b_k2;
    assign w_y1    = w_abp ? i_b_k1 : i_c_k1;

    // stage a: two products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_m0 <= PW'(w_x0) * PW'(w_y0);
            r_m1 <= w_dot ? {PW{1'b0}} : PW'(w_x1) * PW'(w_y1);
        end
    end

    // stage b: cross component (or plain dot term)
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_b) begin
            r_t <= TW'(r_m0) - TW'(r_m1);
        end
    end

    // stage c operand select: scalar triple uses a_k * t_k
    assign w_tri_s = (i_ctl.act_c == ACT_TRIPLE_S);
    assign w_u0    = w_tri_s ? i_ad_k : i_ad_k1;
    assign w_v0    = w_tri_s ? r_t : i_t_k2;

    // stage c: second products, carry t along for the merge
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_c) begin
            r_q0  <= QW'(w_u0) * QW'(w_v0);
            r_q1  <= w_tri_s ? {QW{1'b0}} : QW'(i_ad_k2) * QW'(i_t_k1);
            r_t_c <= r_t;
        end
    end

    assign o_t   = r_t;
    assign o_t_c = r_t_c;
    assign o_q0  = r_q0;
    assign o_q1  = r_q1;

endmodule

`default_nettype wire

[src/vtp_merge.sv]
// ----------------------------------------------------------------------------
// vtp_merge
// Combines the three lanes into the scalar and vector result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_merge #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_en,
    input  wire vtp_pkg::t_action                   i_act,
    input  wire logic signed [2*COMPONENT_WIDTH:0]  i_t [3],
    input  wire logic signed [3*COMPONENT_WIDTH:0]  i_q0 [3],
    input  wire logic signed [3*COMPONENT_WIDTH:0]  i_q1 [3],
    output logic signed [vtp_pkg::OUT_WIDTH-1:0]    o_scalar,
    output logic signed [vtp_pkg::OUT_WIDTH-1:0]    o_vec [3]
);
    import vtp_pkg::*;

    localparam int SW = 3 * COMPONENT_WIDTH + 3;
    localparam int EW = (SW > OUT_WIDTH) ? SW : OUT_WIDTH;
    localparam logic signed [SW-1:0] ZERO = '0;

    logic signed [SW-1:0]        w_sum_t;
    logic signed [SW-1:0]        w_sum_q;
    logic signed [SW-1:0]        w_scalar;
    logic signed [SW-1:0]        w_vec [3];
    logic signed [EW-1:0]        w_scalar_e;
    logic signed [EW-1:0]        w_vec_e [3];
    logic signed [OUT_WIDTH-1:0] r_scalar;
    logic signed [OUT_WIDTH-1:0] r_vec [3];

    // lane sums for the two scalar operations
    assign w_sum_t = SW'(i_t[0]) + SW'(i_t[1]) + SW'(i_t[2]);
    assign w_sum_q = SW'(i_q0[0]) + SW'(i_q0[1]) + SW'(i_q0[2]);

    // pick per operation, unused fields zero
    always_comb begin
        w_scalar = ZERO;
        for (int k = 0; k < 3; k++) begin
            w_vec[k] = ZERO;
        end
        case (i_act)
            ACT_DOT: begin
                w_scalar = w_sum_t;
            end
            ACT_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    w_vec[k] = SW'(i_t[k]);
                end
            end
            ACT_TRIPLE_S: begin
                w_scalar = w_sum_q;
            end
            ACT_TRIPLE_V: begin
                for (int k = 0; k < 3; k++) begin
                    w_vec[k] = SW'(i_q0[k]) - SW'(i_q1[k]);
                end
            end
            default: begin
                w_scalar = ZERO;
            end
        endcase
    end

    // sign extend or wrap to the result width
    always_comb begin
        w_scalar_e = EW'(w_scalar);
        for (int k = 0; k < 3; k++) begin
            w_vec_e[k] = EW'(w_vec[k]);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scalar <= w_scalar_e[OUT_WIDTH-1:0];
            for (int k = 0; k < 3; k++) begin
                r_vec[k] <= w_vec_e[k][OUT_WIDTH-1:0];
            end
        end
    end

    assign o_scalar = r_scalar;
    assign o_vec    = r_vec;

endmodule

`default_nettype wire

[src/vector_triple_product_unit_top.sv]
// ----------------------------------------------------------------------------
// vector_triple_product_unit_top
// Dot, cross, scalar triple and vector triple products of three 3D vectors.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | i_valid / o_ready   | i_action, i_a_*, i_b_*, i_c_*
//  output  | o_valid / i_ready   | o_scalar_out, o_vec_x, o_vec_y, o_vec_z
//
//  four register stages: products, first cross, second products, merge;
//  one beat accepted per cycle while the output side is not stalled
//  reset clears only the stage valid bits; no clearing pass, no state
//  a stall holds only the stages behind a full stage, so bubbles close up
// ----------------------------------------------------------------------------
`default_nettype none

module vector_triple_product_unit_top #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_valid,
    output logic                                    o_ready,
    input  wire logic [1:0]                         i_action,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_b_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_c_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_c_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0]  i_c_z,
    output logic                                    o_valid,
    input  wire                                     i_ready,
    output logic signed [vtp_pkg::OUT_WIDTH-1:0]    o_scalar_out,
    output logic signed [vtp_pkg::OUT_WIDTH-1:0]    o_vec_x,
    output logic signed [vtp_pkg::OUT_WIDTH-1:0]    o_vec_y,
    output logic signed [vtp_pkg::OUT_WIDTH-1:0]    o_vec_z
);
    import vtp_pkg::*;

    localparam int TW = 2 * COMPONENT_WIDTH + 1;
    localparam int QW = 3 * COMPONENT_WIDTH + 1;

    logic [3:0]                        r_vld;
    logic [3:0]                        w_rdy;
    t_action                           w_act_in;
    t_action                           r_act_a, r_act_b, r_act_c;
    logic signed [COMPONENT_WIDTH-1:0] w_a [3];
    logic signed [COMPONENT_WIDTH-1:0] w_b [3];
    logic signed [COMPONENT_WIDTH-1:0] w_c [3];
    logic signed [COMPONENT_WIDTH-1:0] r_a_a [3];
    logic signed [COMPONENT_WIDTH-1:0] r_a_b [3];
    logic signed [TW-1:0]              w_t [3];
    logic signed [TW-1:0]              w_t_c [3];
    logic signed [QW-1:0]              w_q0 [3];
    logic signed [QW-1:0]              w_q1 [3];
    logic signed [OUT_WIDTH-1:0]       w_vec [3];
    t_lane_ctl                         w_ctl;

    assign w_act_in = t_action'(i_action);
    assign w_a = '{i_a_x, i_a_y, i_a_z};
    assign w_b = '{i_b_x, i_b_y, i_b_z};
    assign w_c = '{i_c_x, i_c_y, i_c_z};

    // ready chain: a stage moves when it is empty or the next one moves
    assign w_rdy[3] = !r_vld[3] || i_ready;
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // lane stage enables and operation codes
    assign w_ctl.en_a  = i_valid && w_rdy[0];
    assign w_ctl.en_b  = r_vld[0] && w_rdy[1];
    assign w_ctl.en_c  = r_vld[1] && w_rdy[2];
    assign w_ctl.act_a = w_act_in;
    assign w_ctl.act_c = r_act_b;

    // operation code and vector a travel alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_ctl.en_a) begin
            r_act_a <= w_act_in;
            r_a_a   <= w_a;
        end
        if (w_ctl.en_b) begin
            r_act_b <= r_act_a;
            r_a_b   <= r_a_a;
        end
        if (w_ctl.en_c) begin
            r_act_c <= r_act_b;
        end
    end

    // one lane per vector component
    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        vtp_lane #(
            .COMPONENT_WIDTH(COMPONENT_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_a_k   (w_a[k]),
            .i_a_k1  (w_a[K1]),
            .i_a_k2  (w_a[K2]),
            .i_b_k   (w_b[k]),
            .i_b_k1  (w_b[K1]),
            .i_b_k2  (w_b[K2]),
            .i_c_k1  (w_c[K1]),
            .i_c_k2  (w_c[K2]),
            .i_ad_k  (r_a_b[k]),
            .i_ad_k1 (r_a_b[K1]),
            .i_ad_k2 (r_a_b[K2]),
            .i_t_k1  (w_t[K1]),
            .i_t_k2  (w_t[K2]),
            .o_t     (w_t[k]),
            .o_t_c   (w_t_c[k]),
            .o_q0    (w_q0[k]),
            .o_q1    (w_q1[k])
        );
    end

    // merge stage and result registers
    vtp_merge #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (r_vld[2] && w_rdy[3]),
        .i_act    (r_act_c),
        .i_t      (w_t_c),
        .i_q0     (w_q0),
        .i_q1     (w_q1),
        .o_scalar (o_scalar_out),
        .o_vec    (w_vec)
    );

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[3];
    assign o_vec_x = w_vec[0];
    assign o_vec_y = w_vec[1];
    assign o_vec_z = w_vec[2];

`ifndef SYNTH
    // a full first stage that cannot move keeps its beat
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !w_rdy[1] |=> r_vld[0])
        else $error("stage a dropped a stalled beat");

    // a beat entering the merge shows up as a result next cycle
    a_merge_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && w_rdy[3] |=> o_valid)
        else $error("merged beat did not reach the output");

    // scalar operations leave the vector fields at zero
    a_vec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_vld[2] && w_rdy[3])
        && ($past(r_act_c) == ACT_DOT || $past(r_act_c) == ACT_TRIPLE_S)
        |-> o_vec_x == '0 && o_vec_y == '0 && o_vec_z == '0)
        else $error("vector field not zero on a scalar operation");

    // vector operations leave the scalar field at zero
    a_scalar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_vld[2] && w_rdy[3])
        && ($past(r_act_c) == ACT_CROSS || $past(r_act_c) == ACT_TRIPLE_V)
        |-> o_scalar_out == '0)
        else $error("scalar field not zero on a vector operation");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector triple product unit: beats cover
// every operation at the component extremes, then random vectors under
// random idling on both sides; each result is checked against an
// exact 64-bit integer model of the products.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import vtp_pkg::*;

    localparam int CW = 16;
    localparam int N_RANDOM = 1930;
    localparam int CALM_FIRST = 700;
    localparam int CALM_LAST = 1000;
    localparam int HOLD_AT = 500;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_AT = 1200;
    localparam int IDLE_PCT = 31;

    // one input beat: operation and the nine vector components
    typedef struct packed {
        t_action                act;
        logic signed [CW-1:0]   ax;
        logic signed [CW-1:0]   ay;
        logic signed [CW-1:0]   az;
        logic signed [CW-1:0]   bx;
        logic signed [CW-1:0]   by;
        logic signed [CW-1:0]   bz;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [CW-1:0]   cz;
    } t_beat;

    // one result beat
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] scalar;
        logic signed [OUT_WIDTH-1:0] vx;
        logic signed [OUT_WIDTH-1:0] vy;
        logic signed [OUT_WIDTH-1:0] vz;
    } t_products;

    // expected products in arrival order
    class product_scoreboard;
        t_products expected_q[$];
        int n_err;

        function new();
            n_err = 0;
        endfunction

        // exact integer products, truncated to the result width
        function t_products predict_products(t_beat bt);
            longint a[3];
            longint b[3];
            longint c[3];
            longint t[3];
            longint v[3];
            longint s;
            t_products r;
            a[0] = $signed(bt.ax); a[1] = $signed(bt.ay); a[2] = $signed(bt.az);
            b[0] = $signed(bt.bx); b[1] = $signed(bt.by); b[2] = $signed(bt.bz);
            c[0] = $signed(bt.cx); c[1] = $signed(bt.cy); c[2] = $signed(bt.cz);
            s = 0;
            for (int i = 0; i < 3; i++) v[i] = 0;
            // b x c feeds both triple products
            t[0] = b[1] * c[2] - b[2] * c[1];
            t[1] = b[2] * c[0] - b[0] * c[2];
            t[2] = b[0] * c[1] - b[1] * c[0];
            case (bt.act)
                ACT_DOT: begin
                    s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                end
                ACT_CROSS: begin
                    v[0] = a[1] * b[2] - a[2] * b[1];
                    v[1] = a[2] * b[0] - a[0] * b[2];
                    v[2] = a[0] * b[1] - a[1] * b[0];
                end
                ACT_TRIPLE_S: begin
                    s = a[0] * t[0] + a[1] * t[1] + a[2] * t[2];
                end
                default: begin
                    v[0] = a[1] * t[2] - a[2] * t[1];
                    v[1] = a[2] * t[0] - a[0] * t[2];
                    v[2] = a[0] * t[1] - a[1] * t[0];
                end
            endcase
            r.scalar = s[OUT_WIDTH-1:0];
            r.vx = v[0][OUT_WIDTH-1:0];
            r.vy = v[1][OUT_WIDTH-1:0];
            r.vz = v[2][OUT_WIDTH-1:0];
            return r;
        endfunction

        function void note_beat(t_beat bt);
            expected_q.push_back(predict_products(bt));
        endfunction

        function void compare_field(string name, logic signed [OUT_WIDTH-1:0] want,
                                    logic signed [OUT_WIDTH-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_err++;
            end
        endfunction

        function void check_result(t_products got);
            t_products want;
            if (expected_q.size() == 0) begin
                $error("result beat with no expected products waiting");
                n_err++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("scalar_out", want.scalar, got.scalar);
            compare_field("vec_x", want.vx, got.vx);
            compare_field("vec_y", want.vy, got.vy);
            compare_field("vec_z", want.vz, got.vz);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_beat beat_drv = '0;
    logic o_ready;
    logic o_valid;
    t_products res;

    product_scoreboard sb;
    int n_sent = 0;

    always #2 i_clk = ~i_clk;

    vector_triple_product_unit_top #(
        .COMPONENT_WIDTH(CW)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_action(beat_drv.act),
        .i_a_x(beat_drv.ax),
        .i_a_y(beat_drv.ay),
        .i_a_z(beat_drv.az),
        .i_b_x(beat_drv.bx),
        .i_b_y(beat_drv.by),
        .i_b_z(beat_drv.bz),
        .i_c_x(beat_drv.cx),
        .i_c_y(beat_drv.cy),
        .i_c_z(beat_drv.cz),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_scalar_out(res.scalar),
        .o_vec_x(res.vx),
        .o_vec_y(res.vy),
        .o_vec_z(res.vz)
    );

    function automatic bit in_calm_stretch();
        return n_sent >= CALM_FIRST && n_sent < CALM_LAST;
    endfunction

    // extreme component values for directed beats, by pattern and position
    function automatic logic signed [CW-1:0] extreme_comp(int pat, int idx);
        case (pat)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return (idx % 2 == 0) ? 16'sh7fff : 16'sh8000;
            3: return (idx % 2 == 0) ? 16'sh8000 : 16'sh7fff;
            4: return (idx % 3 == 0) ? 16'sd1 : ((idx % 3 == 1) ? -16'sd1 : 16'sd0);
            default: return (idx < 6) ? 16'sd0 : 16'sh8000;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] random_comp();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return ($urandom_range(1) == 1) ? -16'sd1 : 16'sd0;
            default: return CW'($urandom);
        endcase
    endfunction

    // offer one beat after a random gap (none in the calm stretch) and wait for acceptance
    task automatic send_beat(t_beat bt);
        int gap;
        gap = 0;
        if (!in_calm_stretch())
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        beat_drv <= bt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    // wait until every expected result beat has come back
    task automatic drain_results();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // record accepted input beats and check accepted result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_beat(beat_drv);
            if (o_valid && i_ready) sb.check_result(res);
        end
    end

    // result side: random stalls, one long hold-off, a calm stretch
    initial begin
        int held_cycles;
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && !held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                held_cycles = 0;
                while (held_cycles < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held_cycles++;
                end
            end else begin
                i_ready <= in_calm_stretch() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // stimulus
    initial begin
        t_beat bt;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operation at the component extremes, c ignored by dot and cross
        for (int pat = 0; pat < 6; pat++) begin
            for (int op = 0; op < 4; op++) begin
                bt.act = t_action'(op);
                bt.ax = extreme_comp(pat, 0);
                bt.ay = extreme_comp(pat, 1);
                bt.az = extreme_comp(pat, 2);
                bt.bx = extreme_comp(pat, 3);
                bt.by = extreme_comp(pat, 4);
                bt.bz = extreme_comp(pat, 5);
                bt.cx = extreme_comp(pat, 6);
                bt.cy = extreme_comp(pat, 7);
                bt.cz = extreme_comp(pat, 8);
                send_beat(bt);
            end
        end

        // random vectors and operations
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == DRAIN_AT) begin
                i_valid <= 1'b0;
                drain_results();
            end
            bt.act = t_action'($urandom_range(3));
            bt.ax = random_comp();
            bt.ay = random_comp();
            bt.az = random_comp();
            bt.bx = random_comp();
            bt.by = random_comp();
            bt.bz = random_comp();
            bt.cx = random_comp();
            bt.cy = random_comp();
            bt.cz = random_comp();
            send_beat(bt);
        end
        i_valid <= 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.n_err == 0) begin
            $display("vector_triple_product_unit_top test passed");
        end else begin
            $display("vector_triple_product_unit_top test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("vector_triple_product_unit_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
